// ----- design/scfu_pkg.sv -----
`default_nettype none
package scfu_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int COORD_BITS_DEF   = 24;
  localparam int LENGTH_BITS_DEF  = 16;
  localparam int MAG_BITS         = 30;

  localparam logic [1:0] REQ_MOVE  = 2'd0;
  localparam logic [1:0] REQ_PLACE = 2'd1;
  localparam logic [1:0] REQ_LEN   = 2'd2;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- design/scfu_cell.sv -----
`default_nettype none
module scfu_cell #(
  parameter int W = 8
) (
  input  wire logic              clk,
  input  wire scfu_pkg::cell_ctl_t ctl,
  input  wire logic [W-1:0]      shift_in,
  input  wire logic [W-1:0]      load_val,
  output logic      [W-1:0]      q
);

  logic [W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= load_val;
    end else if (ctl.shift) begin
      val_r <= shift_in;
    end
  end

  assign q = val_r;

endmodule
`default_nettype wire

// ----- design/scfu_pull.sv -----
`default_nettype none
module scfu_pull #(
  parameter int CB = scfu_pkg::COORD_BITS_DEF,
  parameter int LB = scfu_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [CB-1:0] hx,
  input  wire logic signed [CB-1:0] hy,
  input  wire logic signed [CB-1:0] tx,
  input  wire logic signed [CB-1:0] ty,
  input  wire logic        [LB-1:0] len,
  output logic                      done,
  output logic signed      [CB-1:0] nx,
  output logic signed      [CB-1:0] ny
);

  localparam int MW  = scfu_pkg::MAG_BITS;
  localparam int AW  = CB + 1;
  localparam int SW  = 2 * MW + 1;
  localparam int NW  = LB + MW + 1;
  localparam int RSW = NW + 2;
  localparam int CW  = $clog2(NW + 1);
  localparam logic signed [RSW-1:0] CMAX = RSW'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic signed [RSW-1:0] CMIN = -CMAX - RSW'(1);

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_NORM = 7'b0000010,
    P_SQ   = 7'b0000100,
    P_SUM  = 7'b0001000,
    P_ROOT = 7'b0010000,
    P_DIV  = 7'b0100000,
    P_FIN  = 7'b1000000
  } pstate_t;

  pstate_t st_r;
  logic signed [CB-1:0] hx_r, hy_r, nx_r, ny_r;
  logic                 sx_r, sy_r;
  logic [AW-1:0]        ax_r, ay_r;
  logic [LB-1:0]        len_r;
  logic [2*MW-1:0]      sqx_r, sqy_r;
  logic [SW-1:0]        v_r, r_r, b_r;
  logic [NW-1:0]        numx_r, numy_r;
  logic [MW:0]          remx_r, remy_r, n_r;
  logic [CW-1:0]        cnt_r;

  logic signed [AW-1:0] dx, dy;
  logic [MW-1:0]        axm, aym;
  logic [SW-1:0]        rb;
  logic                 root_ge;
  logic [MW:0]          n_sel;
  logic [MW+1:0]        tx_rem, ty_rem;
  logic                 gex, gey;
  logic signed [RSW-1:0] hxw, hyw, qx, qy, sumx, sumy, coin;

  function automatic logic signed [CB-1:0] sat(input logic signed [RSW-1:0] v);
    logic signed [CB-1:0] o;
    if (v > CMAX) o = CB'(CMAX);
    else if (v < CMIN) o = CB'(CMIN);
    else o = v[CB-1:0];
    return o;
  endfunction

  always_comb begin
    dx      = {hx[CB-1], hx} - {tx[CB-1], tx};
    dy      = {hy[CB-1], hy} - {ty[CB-1], ty};
    axm     = MW'(ax_r);
    aym     = MW'(ay_r);
    rb      = r_r + b_r;
    root_ge = v_r >= rb;
    n_sel   = (r_r[MW:0] == '0) ? (MW+1)'(1) : r_r[MW:0];
    tx_rem  = {remx_r, numx_r[NW-1]};
    ty_rem  = {remy_r, numy_r[NW-1]};
    gex     = tx_rem >= {1'b0, n_r};
    gey     = ty_rem >= {1'b0, n_r};
    hxw     = {{(RSW-CB){hx_r[CB-1]}}, hx_r};
    hyw     = {{(RSW-CB){hy_r[CB-1]}}, hy_r};
    qx      = {2'b00, numx_r};
    qy      = {2'b00, numy_r};
    sumx    = sx_r ? hxw + qx : hxw - qx;
    sumy    = sy_r ? hyw + qy : hyw - qy;
    coin    = {{(RSW-CB){hx[CB-1]}}, hx} - RSW'(len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE;
    end else begin
      unique case (st_r)
        P_IDLE: begin
          if (start) begin
            hx_r  <= hx;
            hy_r  <= hy;
            len_r <= len;
            sx_r  <= dx[AW-1];
            sy_r  <= dy[AW-1];
            ax_r  <= dx[AW-1] ? AW'(-dx) : AW'(dx);
            ay_r  <= dy[AW-1] ? AW'(-dy) : AW'(dy);
            if (dx == '0 && dy == '0) begin
              nx_r <= sat(coin);
              ny_r <= hy;
              st_r <= P_FIN;
            end else begin
              st_r <= P_NORM;
            end
          end
        end
        P_NORM: begin
          if (64'(ax_r) >= (64'd1 << MW) || 64'(ay_r) >= (64'd1 << MW)) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else begin
            st_r <= P_SQ;
          end
        end
        P_SQ: begin
          sqx_r <= axm * axm;
          sqy_r <= aym * aym;
          st_r  <= P_SUM;
        end
        P_SUM: begin
          v_r    <= SW'(sqx_r) + SW'(sqy_r);
          numx_r <= len_r * axm;
          numy_r <= len_r * aym;
          r_r    <= '0;
          b_r    <= SW'(1) << (2 * MW);
          cnt_r  <= '0;
          st_r   <= P_ROOT;
        end
        P_ROOT: begin
          if (cnt_r == CW'(MW + 1)) begin
            n_r    <= n_sel;
            numx_r <= numx_r + NW'(n_sel >> 1);
            numy_r <= numy_r + NW'(n_sel >> 1);
            remx_r <= '0;
            remy_r <= '0;
            cnt_r  <= '0;
            st_r   <= P_DIV;
          end else begin
            if (root_ge) begin
              v_r <= v_r - rb;
              r_r <= (r_r >> 1) + b_r;
            end else begin
              r_r <= r_r >> 1;
            end
            b_r   <= b_r >> 2;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        P_DIV: begin
          if (cnt_r == CW'(NW)) begin
            nx_r <= sat(sumx);
            ny_r <= sat(sumy);
            st_r <= P_FIN;
          end else begin
            remx_r <= gex ? (MW+1)'(tx_rem - {1'b0, n_r}) : (MW+1)'(tx_rem);
            remy_r <= gey ? (MW+1)'(ty_rem - {1'b0, n_r}) : (MW+1)'(ty_rem);
            numx_r <= {numx_r[NW-2:0], gex};
            numy_r <= {numy_r[NW-2:0], gey};
            cnt_r  <= cnt_r + CW'(1);
          end
        end
        P_FIN: begin
          st_r <= P_IDLE;
        end
        default: begin
          st_r <= P_IDLE;
        end
      endcase
    end
  end

  assign done = (st_r == P_FIN);
  assign nx   = nx_r;
  assign ny   = ny_r;

endmodule
`default_nettype wire

// ----- design/segment_chain_follow_unit.sv -----
`default_nettype none
// Segment chain follower.
// Input channel (in_valid/in_ready): one request word. Move sets the head and
// pulls every tail in turn; place puts all points on one spot; a length word
// writes one segment length and gives no output.
// Output channel (out_valid/out_ready): move and place return points
// 0..segment_count, one word each, out_last on the final point.
// Config channel (cfg_valid/cfg_ready): writes segment_count (clamped to
// 1..MAX_SEGMENTS) and reloads lengths to count minus index; taken when idle,
// with no input word offered and no result word waiting.
// Points and lengths sit in rings of cells that rotate one place per cycle
// while shifted; they hold while a tail is pulled or the receiver stalls. A
// move pulls each tail through one shared iterative root and divide unit,
// after halving offsets wider than MAG_BITS; a tail sitting on its head skips
// that unit and is set len to its left. Short chains then rotate the rings
// back into line. Move and place step all MAX_SEGMENTS+1 points out for emit.
// The result register takes a new word in each cycle the receiver accepts one;
// when the receiver stalls the ring holds and no new request is taken until done.
// Reset: points at origin, lengths MAX_SEGMENTS - i pixels, count MAX.
module segment_chain_follow_unit #(
  parameter int MAX_SEGMENTS = scfu_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = scfu_pkg::COORD_BITS_DEF,
  parameter int LENGTH_BITS  = scfu_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic signed [COORD_BITS-1:0] in_pos_x,
  input  wire logic signed [COORD_BITS-1:0] in_pos_y,
  input  wire logic [3:0]                   in_seg_index,
  input  wire logic [LENGTH_BITS-1:0]       in_seg_length,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [4:0]                        out_point_index,
  output logic signed [COORD_BITS-1:0]      out_point_x,
  output logic signed [COORD_BITS-1:0]      out_point_y,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [4:0]                   cfg_segment_count
);

  localparam int CB   = COORD_BITS;
  localparam int LB   = LENGTH_BITS;
  localparam int NP   = MAX_SEGMENTS + 1;
  localparam int CNTW = $clog2(NP + 1);
  localparam logic [31:0] LMAX = (32'd1 << LB) - 32'd1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_PULL  = 6'b000100,
    S_WAIT  = 6'b001000,
    S_ALIGN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t              state_r;
  logic [CNTW-1:0]     cnt_r, count_r;
  logic signed [CB-1:0] hx_r, hy_r;
  logic                out_valid_r, out_last_r;
  logic [4:0]          out_idx_r;
  logic signed [CB-1:0] out_x_r, out_y_r;

  logic [2*CB-1:0]     pt [NP];
  logic [LB-1:0]       ln [MAX_SEGMENTS];
  logic [2*CB-1:0]     pt_ring_in;
  scfu_pkg::cell_ctl_t pt_ctl, ln_ctl_sh;
  logic                in_acc, cfg_acc, slot_free;
  logic [CNTW-1:0]     cfg_cnt;
  logic                pull_start, pull_done;
  logic signed [CB-1:0] pull_x, pull_y;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r && !in_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    if (cfg_segment_count == 5'd0) cfg_cnt = CNTW'(1);
    else if (32'(cfg_segment_count) > 32'(MAX_SEGMENTS)) cfg_cnt = CNTW'(MAX_SEGMENTS);
    else cfg_cnt = CNTW'(cfg_segment_count);
  end

  always_comb begin
    pt_ctl     = '0;
    ln_ctl_sh  = '0;
    pt_ring_in = pt[0];
    if (!rst_n || (in_acc && in_req_type == scfu_pkg::REQ_PLACE)) begin
      pt_ctl.load = 1'b1;
    end
    case (state_r)
      S_HEAD: begin
        pt_ctl.shift = 1'b1;
        pt_ring_in   = {hx_r, hy_r};
      end
      S_WAIT: begin
        if (pull_done) begin
          pt_ctl.shift    = 1'b1;
          ln_ctl_sh.shift = 1'b1;
          pt_ring_in      = {pull_x, pull_y};
        end
      end
      S_ALIGN: begin
        pt_ctl.shift    = 1'b1;
        ln_ctl_sh.shift = 1'b1;
      end
      S_EMIT: begin
        pt_ctl.shift = slot_free;
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < NP; k++) begin : g_pt
    logic [2*CB-1:0] ld;
    assign ld = rst_n ? {in_pos_x, in_pos_y} : '0;
    scfu_cell #(.W(2 * CB)) u_cell (
      .clk      (clk),
      .ctl      (pt_ctl),
      .shift_in ((k == NP - 1) ? pt_ring_in : pt[(k + 1) % NP]),
      .load_val (ld),
      .q        (pt[k])
    );
  end

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_ln
    scfu_pkg::cell_ctl_t ctl;
    logic [LB-1:0]       ld;
    logic [31:0]         pix, wl;
    always_comb begin
      ctl = ln_ctl_sh;
      if (!rst_n) begin
        pix = 32'(MAX_SEGMENTS - k);
      end else if (32'(cfg_cnt) > 32'(k)) begin
        pix = 32'(cfg_cnt) - 32'(k);
      end else begin
        pix = 32'd0;
      end
      wl = pix << 8;
      if (wl > LMAX) wl = LMAX;
      if (!rst_n || cfg_acc) begin
        ctl.load = 1'b1;
        ld       = LB'(wl);
      end else begin
        ctl.load = in_acc && in_req_type == scfu_pkg::REQ_LEN &&
                   int'(in_seg_index) == k;
        ld       = in_seg_length;
      end
    end
    scfu_cell #(.W(LB)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .shift_in ((k == MAX_SEGMENTS - 1) ? ln[0] : ln[(k + 1) % MAX_SEGMENTS]),
      .load_val (ld),
      .q        (ln[k])
    );
  end

  assign pull_start = (state_r == S_PULL);

  scfu_pull #(.CB(CB), .LB(LB)) u_pull (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pull_start),
    .hx    (hx_r),
    .hy    (hy_r),
    .tx    (pt[0][2*CB-1:CB]),
    .ty    (pt[0][CB-1:0]),
    .len   (ln[0]),
    .done  (pull_done),
    .nx    (pull_x),
    .ny    (pull_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNTW'(MAX_SEGMENTS);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !(state_r == S_EMIT && slot_free)) out_valid_r <= 1'b0;
      if (cfg_acc) count_r <= cfg_cnt;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cnt_r <= '0;
            hx_r  <= in_pos_x;
            hy_r  <= in_pos_y;
            if (in_req_type == scfu_pkg::REQ_MOVE) state_r <= S_HEAD;
            else if (in_req_type == scfu_pkg::REQ_PLACE) state_r <= S_EMIT;
          end
        end
        S_HEAD: begin
          state_r <= S_PULL;
        end
        S_PULL: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (pull_done) begin
            hx_r  <= pull_x;
            hy_r  <= pull_y;
            if (cnt_r == count_r - CNTW'(1)) begin
              if (count_r == CNTW'(MAX_SEGMENTS)) begin
                cnt_r   <= '0;
                state_r <= S_EMIT;
              end else begin
                cnt_r   <= cnt_r + CNTW'(1);
                state_r <= S_ALIGN;
              end
            end else begin
              cnt_r   <= cnt_r + CNTW'(1);
              state_r <= S_PULL;
            end
          end
        end
        S_ALIGN: begin
          if (cnt_r == CNTW'(MAX_SEGMENTS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= (cnt_r <= count_r);
            out_idx_r   <= 5'(cnt_r);
            out_x_r     <= pt[0][2*CB-1:CB];
            out_y_r     <= pt[0][CB-1:0];
            out_last_r  <= (cnt_r == count_r);
            cnt_r       <= cnt_r + CNTW'(1);
            if (cnt_r == CNTW'(NP - 1)) state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_idx_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_last        = out_last_r;

`ifndef SYNTH
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_idx_r == 5'(count_r))
    else $error("last flag off the final point");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    pull_done |-> state_r == S_WAIT)
    else $error("pull result outside wait");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> state_r == S_IDLE && !out_valid_r)
    else $error("reset did not clear control");
`endif

endmodule
`default_nettype wire
